FILE: rtl/pfx_pkg.sv
// Shared types, constants and helper functions for the packet header field extractor.
// Used by the channel interfaces and every RTL module of the block.
`timescale 1ns / 1ps

package pfx_pkg;

	localparam int MAX_FIELDS     = 6;
	localparam int MAX_FIELD_BITS = 64;
	localparam int BYTE_BITS      = 8;
	localparam int QUEUE_DEPTH    = 4;

	localparam int WIDTH_W  = 7;
	localparam int HBYTES_W = 6;
	localparam int FCOUNT_W = 3;
	localparam int IDX_W    = 3;
	localparam int LEFT_W   = $clog2(BYTE_BITS + 1);
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WIDTH_W-1:0]  MAX_WIDTH_CODE = WIDTH_W'(MAX_FIELD_BITS);
	localparam logic [IDX_W-1:0]    MAX_FIELD_CODE = IDX_W'(MAX_FIELDS);
	localparam logic [LEFT_W-1:0]   FULL_BYTE      = LEFT_W'(BYTE_BITS);

	// register indexes on the configuration port
	localparam int REG_IDX_W = 3;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_FIELD_COUNT  = 3'd0;
	localparam reg_idx_t REG_WIDTH_A      = 3'd1;
	localparam reg_idx_t REG_WIDTH_B      = 3'd2;
	localparam reg_idx_t REG_WIDTH_C      = 3'd3;
	localparam reg_idx_t REG_WIDTH_D      = 3'd4;
	localparam reg_idx_t REG_WIDTH_E      = 3'd5;
	localparam reg_idx_t REG_WIDTH_F      = 3'd6;
	localparam reg_idx_t REG_HEADER_BYTES = 3'd7;

	// result kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIELD   = 2'd0;
	localparam kind_t KIND_PAYLOAD = 2'd1;
	localparam kind_t KIND_SHORT   = 2'd2;

	// byte classes decided by the front end
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_HEADER  = 2'd0;
	localparam cls_t CLS_PAYLOAD = 2'd1;
	localparam cls_t CLS_SHORT   = 2'd2;

	typedef struct packed {
		logic [FCOUNT_W-1:0]                  field_count;
		logic [MAX_FIELDS-1:0][WIDTH_W-1:0]   widths;
		logic [HBYTES_W-1:0]                  header_bytes;
	} cfg_t;

	typedef struct packed {
		cls_t                 cls;
		logic [BYTE_BITS-1:0] data;
		logic                 pkt_end;
		logic                 hdr_last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [IDX_W-1:0] fields_used(cfg_t c);
		return (c.field_count > MAX_FIELD_CODE) ? MAX_FIELD_CODE : c.field_count;
	endfunction

	function automatic logic [WIDTH_W-1:0] width_of(cfg_t c, logic [IDX_W-1:0] f);
		logic [WIDTH_W-1:0] w;
		w = '0;
		if (f < MAX_FIELD_CODE) begin
			w = c.widths[f];
		end
		return (w > MAX_WIDTH_CODE) ? MAX_WIDTH_CODE : w;
	endfunction

	function automatic logic [BYTE_BITS-1:0] low_mask(logic [LEFT_W-1:0] n);
		logic [BYTE_BITS:0] m;
		m = ((BYTE_BITS+1)'(1) << n) - (BYTE_BITS+1)'(1);
		return m[BYTE_BITS-1:0];
	endfunction

endpackage

FILE: rtl/pfx_if.sv
// Valid/ready channel interfaces: packet bytes in, extracted results out.
// Depends on pfx_pkg for widths and codes.
`timescale 1ns / 1ps

interface pfx_in_if;
	logic                          valid;
	logic                          ready;
	logic [pfx_pkg::BYTE_BITS-1:0] data_byte;
	logic                          packet_end;

	modport source (output valid, output data_byte, output packet_end, input ready);
	modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface pfx_out_if;
	logic                               valid;
	logic                               ready;
	pfx_pkg::kind_t                     kind;
	logic [pfx_pkg::IDX_W-1:0]          field_index;
	logic [pfx_pkg::MAX_FIELD_BITS-1:0] field_value;
	logic                               end_of_packet;
	logic                               last;

	modport source (output valid, output kind, output field_index, output field_value,
		output end_of_packet, output last, input ready);
	modport sink   (input valid, input kind, input field_index, input field_value,
		input end_of_packet, input last, output ready);
endinterface

FILE: rtl/pfx_front.sv
// Front end: accepts packet bytes and tags each as header, payload or short-packet error.
// Tracks the header byte count per packet. Depends on pfx_pkg and pfx_in_if.
`timescale 1ns / 1ps

module pfx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  pfx_pkg::cfg_t     cfg,
	pfx_in_if.sink            pkt_in,
	input  pfx_pkg::qstat_t   qstat,
	output logic              push,
	output pfx_pkg::entry_t   push_entry
);

	logic [pfx_pkg::HBYTES_W-1:0] hcount_q, hcount_inc, hcount_n;
	logic                         in_payload_q, in_payload_n;

	always_comb begin
		pkt_in.ready = !qstat.full;
		push         = pkt_in.valid && pkt_in.ready;
		hcount_inc   = hcount_q + pfx_pkg::HBYTES_W'(1);

		push_entry.data     = pkt_in.data_byte;
		push_entry.pkt_end  = pkt_in.packet_end;
		push_entry.hdr_last = 1'b0;
		push_entry.cls      = pfx_pkg::CLS_HEADER;
		hcount_n            = hcount_q;
		in_payload_n        = in_payload_q;

		if (in_payload_q || cfg.header_bytes == '0) begin
			push_entry.cls = pfx_pkg::CLS_PAYLOAD;
			in_payload_n   = !pkt_in.packet_end;
			hcount_n       = '0;
		end else if (pkt_in.packet_end && hcount_inc < cfg.header_bytes) begin
			push_entry.cls = pfx_pkg::CLS_SHORT;
			hcount_n       = '0;
		end else if (hcount_inc >= cfg.header_bytes) begin
			push_entry.hdr_last = 1'b1;
			hcount_n            = '0;
			in_payload_n        = !pkt_in.packet_end;
		end else begin
			hcount_n = hcount_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcount_q     <= '0;
			in_payload_q <= 1'b0;
		end else if (push) begin
			hcount_q     <= hcount_n;
			in_payload_q <= in_payload_n;
		end
	end

endmodule

FILE: rtl/pfx_queue.sv
// Short FIFO of classified bytes between the front and back ends.
// Depends on pfx_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pfx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfx_pkg::entry_t   push_entry,
	input  logic              pop,
	output pfx_pkg::entry_t   head,
	output pfx_pkg::qstat_t   qstat
);

	pfx_pkg::entry_t                mem_q [pfx_pkg::QUEUE_DEPTH];
	logic [pfx_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [pfx_pkg::QCNT_W-1:0]     count_q;

	always_comb begin
		qstat.full  = count_q == pfx_pkg::QCNT_W'(pfx_pkg::QUEUE_DEPTH);
		qstat.empty = count_q == '0;
		head        = mem_q[rd_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + pfx_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + pfx_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + pfx_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pfx_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/pfx_back.sv
// Back end: cuts header bytes into fields, passes payload and errors, drives the output register.
// One result per cycle unless res_out stalls; bits up to the next field boundary are taken in a single step.
// Depends on pfx_pkg, pfx_out_if.
`timescale 1ns / 1ps

module pfx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pfx_pkg::cfg_t     cfg,
	input  pfx_pkg::entry_t   head,
	input  pfx_pkg::qstat_t   qstat,
	output logic              pop,
	pfx_out_if.source         res_out
);

	localparam int FB = pfx_pkg::MAX_FIELD_BITS;
	localparam int WW = pfx_pkg::WIDTH_W;
	localparam int LW = pfx_pkg::LEFT_W;
	localparam int IW = pfx_pkg::IDX_W;

	// field builder state
	logic [FB-1:0] accum_q, accum_n, acc_shift;
	logic [WW-1:0] taken_q, taken_n;
	logic [IW-1:0] cur_q, cur_n;
	logic [LW-1:0] left_q, left_n, k;

	// output register
	logic          ov_q;
	pfx_pkg::kind_t kind_q;
	logic [IW-1:0] index_q;
	logic [FB-1:0] value_q;
	logic          eop_q, last_q;

	logic                          step, emit, done, more;
	logic [IW-1:0]                 used;
	logic [WW-1:0]                 wcur, wnext, rem;
	logic [pfx_pkg::BYTE_BITS-1:0] avail, bits;
	pfx_pkg::kind_t                e_kind;
	logic [IW-1:0]                 e_index;
	logic [FB-1:0]                 e_value;

	always_comb begin
		step  = !qstat.empty && (!ov_q || res_out.ready);
		used  = pfx_pkg::fields_used(cfg);
		wcur  = pfx_pkg::width_of(cfg, cur_q);
		rem   = wcur - taken_q;
		avail = head.data & pfx_pkg::low_mask(left_q);

		k        = '0;
		emit     = 1'b0;
		done     = 1'b1;
		more     = 1'b0;
		wnext    = '0;
		accum_n  = accum_q;
		taken_n  = taken_q;
		cur_n    = cur_q;
		left_n   = left_q;
		e_kind   = pfx_pkg::KIND_FIELD;
		e_index  = '0;
		e_value  = '0;

		if (cur_q < used && wcur != '0) begin
			k = (rem <= WW'(left_q)) ? rem[LW-1:0] : left_q;
		end
		bits      = avail >> (left_q - k);
		acc_shift = (accum_q << k) | FB'(bits);

		unique case (head.cls)
			pfx_pkg::CLS_PAYLOAD: begin
				emit    = 1'b1;
				e_kind  = pfx_pkg::KIND_PAYLOAD;
				e_value = FB'(head.data);
			end
			pfx_pkg::CLS_SHORT: begin
				emit    = 1'b1;
				e_kind  = pfx_pkg::KIND_SHORT;
				accum_n = '0;
				taken_n = '0;
				cur_n   = '0;
			end
			pfx_pkg::CLS_HEADER: begin
				if (cur_q < used) begin
					if (wcur == '0) begin
						// zero-width field reached: emit it empty
						emit    = 1'b1;
						e_index = cur_q;
					end else if (rem <= WW'(left_q)) begin
						emit    = 1'b1;
						e_index = cur_q;
						e_value = acc_shift;
						left_n  = left_q - k;
					end else begin
						accum_n = acc_shift;
						taken_n = taken_q + WW'(left_q);
						left_n  = '0;
					end
				end
				if (emit) begin
					cur_n   = cur_q + IW'(1);
					accum_n = '0;
					taken_n = '0;
					wnext   = pfx_pkg::width_of(cfg, cur_n);
					more    = cur_n < used && (wnext == '0 || WW'(left_n) >= wnext);
					done    = !more;
					// rest of the byte starts the next field, which it cannot complete
					if (done && cur_n < used) begin
						accum_n = FB'(head.data & pfx_pkg::low_mask(left_n));
						taken_n = WW'(left_n);
					end
				end
				if (done && head.hdr_last) begin
					accum_n = '0;
					taken_n = '0;
					cur_n   = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		pop = step && done;

		res_out.valid         = ov_q;
		res_out.kind          = kind_q;
		res_out.field_index   = index_q;
		res_out.field_value   = value_q;
		res_out.end_of_packet = eop_q;
		res_out.last          = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			taken_q <= '0;
			cur_q   <= '0;
			left_q  <= pfx_pkg::FULL_BYTE;
			ov_q    <= 1'b0;
		end else begin
			if (step) begin
				accum_q <= accum_n;
				taken_q <= taken_n;
				cur_q   <= cur_n;
				left_q  <= done ? pfx_pkg::FULL_BYTE : left_n;
			end
			if (step && emit) begin
				ov_q <= 1'b1;
			end else if (res_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q  <= e_kind;
			index_q <= e_index;
			value_q <= e_value;
			eop_q   <= done && head.pkt_end;
			last_q  <= done;
		end
	end

endmodule

FILE: rtl/packet_header_field_extractor_core.sv
// Packet header field extractor top level: configuration registers, front end, queue, back end.
// Depends on pfx_pkg, pfx_if, pfx_front, pfx_queue and pfx_back.
//
// Usage:
//   pkt_in carries packet bytes (data_byte, packet_end), header bits taken MSB first.
//   res_out carries results: kind (field, payload byte, short packet), field_index,
//   field_value, end_of_packet and last, the latter marking the final result of a byte.
//   cfg_we/cfg_index/cfg_data write field_count, the six field widths and header_bytes;
//   write them only while no beat is in flight.
// An accepted byte is written into the queue. The back end takes it from the queue head
//   and, once the output register is free, loads its first result there with res_out.valid high.
// Throughput: one byte per cycle while each byte yields at most one result and res_out
//   does not stall; a byte that completes several fields holds the back end until each
//   of its results has entered the output register, which takes one result per cycle. A
//   four-entry queue absorbs these bursts, and pkt_in.ready drops only when it is full.
// A header byte that completes no field yields no result at all.
// Reset clears the configuration to zero, empties the queue and starts a new packet
//   in the header phase. When res_out stalls, the pending result holds in the output
//   register and the back end waits; the front end keeps taking bytes into the queue
//   until it fills.
`timescale 1ns / 1ps

module packet_header_field_extractor_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  pfx_pkg::reg_idx_t         cfg_index,
	input  logic [pfx_pkg::WIDTH_W-1:0] cfg_data,
	pfx_in_if.sink                    pkt_in,
	pfx_out_if.source                 res_out
);

	pfx_pkg::cfg_t   cfg_q;
	pfx_pkg::qstat_t qstat;
	pfx_pkg::entry_t push_entry, head;
	logic            push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfx_pkg::REG_FIELD_COUNT: begin
					cfg_q.field_count <= cfg_data[pfx_pkg::FCOUNT_W-1:0];
				end
				pfx_pkg::REG_WIDTH_A, pfx_pkg::REG_WIDTH_B, pfx_pkg::REG_WIDTH_C,
				pfx_pkg::REG_WIDTH_D, pfx_pkg::REG_WIDTH_E, pfx_pkg::REG_WIDTH_F: begin
					cfg_q.widths[cfg_index - pfx_pkg::REG_WIDTH_A] <= cfg_data;
				end
				pfx_pkg::REG_HEADER_BYTES: begin
					cfg_q.header_bytes <= cfg_data[pfx_pkg::HBYTES_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pfx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pkt_in     (pkt_in),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	pfx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	pfx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.res_out (res_out)
	);

	a_short_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.kind == pfx_pkg::KIND_SHORT
		|-> res_out.end_of_packet && res_out.last && res_out.field_value == '0)
		else $error("short-packet result without end marks");

	a_eop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.end_of_packet |-> res_out.last)
		else $error("end_of_packet on a result that is not the last of its byte");

	a_payload_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.kind == pfx_pkg::KIND_PAYLOAD
		|-> res_out.last && res_out.field_index == '0
		&& res_out.field_value[pfx_pkg::MAX_FIELD_BITS-1:pfx_pkg::BYTE_BITS] == '0)
		else $error("malformed payload result");

	a_field_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.kind == pfx_pkg::KIND_FIELD
		|-> res_out.field_index < pfx_pkg::fields_used(cfg_q))
		else $error("field index beyond configured field count");

	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |=> !qstat.empty)
		else $error("queue went from full to empty in one cycle");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for packet_header_field_extractor_core.
// Feeds packet bytes through pkt_in and checks every res_out beat against a built-in predictor.
// Depends on rtl/pfx_pkg.sv, rtl/pfx_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		pfx_pkg::kind_t                     kind;
		logic [pfx_pkg::IDX_W-1:0]          index;
		logic [pfx_pkg::MAX_FIELD_BITS-1:0] value;
		logic                               eop;
		logic                               last;
	} field_result_t;

	typedef struct packed {
		logic [pfx_pkg::BYTE_BITS-1:0] data;
		logic                          pend;
	} pkt_byte_t;

	localparam int LONG_HOLD     = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int BYTE_SLOTS    = 1024;
	localparam int RESULT_SLOTS  = 8192;

	logic                        clk    = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we;
	pfx_pkg::reg_idx_t           cfg_index;
	logic [pfx_pkg::WIDTH_W-1:0] cfg_data;

	pfx_in_if  pkt_in();
	pfx_out_if res_out();

	packet_header_field_extractor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt_in    (pkt_in),
		.res_out   (res_out)
	);

	// pending bytes and expected results, each a ring with free-running counters
	pkt_byte_t     byte_store[BYTE_SLOTS];
	int            byte_wr = 0;
	int            byte_rd = 0;
	field_result_t result_store[RESULT_SLOTS];
	int            res_wr = 0;
	int            res_rd = 0;
	field_result_t byte_batch[8];
	int            batch_n;

	// shadow registers
	logic [pfx_pkg::FCOUNT_W-1:0]                       fld_count;
	logic [pfx_pkg::MAX_FIELDS-1:0][pfx_pkg::WIDTH_W-1:0] fld_widths;
	logic [pfx_pkg::HBYTES_W-1:0]                       hdr_len;

	// shadow packet state
	logic [pfx_pkg::MAX_FIELD_BITS-1:0] acc;
	logic [pfx_pkg::WIDTH_W-1:0]        taken;
	logic [pfx_pkg::IDX_W-1:0]          cur_field;
	logic [pfx_pkg::HBYTES_W-1:0]       hdr_seen;
	logic                               in_payload;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	int mismatches      = 0;
	int results_checked = 0;
	int bytes_fed       = 0;
	int settings_used   = 0;

	always #5 clk = ~clk;

	function automatic logic [pfx_pkg::IDX_W-1:0] active_fields();
		return (fld_count > pfx_pkg::IDX_W'(pfx_pkg::MAX_FIELDS)) ?
			pfx_pkg::IDX_W'(pfx_pkg::MAX_FIELDS) : fld_count;
	endfunction

	function automatic logic [pfx_pkg::WIDTH_W-1:0] clamped_width(
		logic [pfx_pkg::IDX_W-1:0] f);
		logic [pfx_pkg::WIDTH_W-1:0] w;
		w = fld_widths[f];
		return (w > pfx_pkg::WIDTH_W'(pfx_pkg::MAX_FIELD_BITS)) ?
			pfx_pkg::WIDTH_W'(pfx_pkg::MAX_FIELD_BITS) : w;
	endfunction

	function automatic void add_result(pfx_pkg::kind_t k, logic [pfx_pkg::IDX_W-1:0] idx,
		logic [pfx_pkg::MAX_FIELD_BITS-1:0] v);
		byte_batch[batch_n] = '{k, idx, v, 1'b0, 1'b0};
		batch_n++;
	endfunction

	function automatic void flush_zero_width();
		while (cur_field < active_fields() && clamped_width(cur_field) == '0) begin
			add_result(pfx_pkg::KIND_FIELD, cur_field, '0);
			cur_field++;
		end
	endfunction

	function automatic void new_packet();
		acc        = '0;
		taken      = '0;
		cur_field  = '0;
		hdr_seen   = '0;
		in_payload = 1'b0;
	endfunction

	// Works out the results of one accepted byte and queues them.
	function automatic void extract_byte(logic [pfx_pkg::BYTE_BITS-1:0] b, logic pend);
		int i;
		batch_n = 0;
		if (in_payload || hdr_len == '0) begin
			add_result(pfx_pkg::KIND_PAYLOAD, '0, pfx_pkg::MAX_FIELD_BITS'(b));
			if (pend)
				new_packet();
			else
				in_payload = 1'b1;
		end else begin
			hdr_seen++;
			if (pend && hdr_seen < hdr_len) begin
				add_result(pfx_pkg::KIND_SHORT, '0, '0);
				new_packet();
			end else begin
				for (i = pfx_pkg::BYTE_BITS - 1; i >= 0; i--) begin
					flush_zero_width();
					if (cur_field < active_fields()) begin
						acc = {acc[pfx_pkg::MAX_FIELD_BITS-2:0], b[i]};
						taken++;
						if (taken >= clamped_width(cur_field)) begin
							add_result(pfx_pkg::KIND_FIELD, cur_field, acc);
							cur_field++;
							acc   = '0;
							taken = '0;
						end
					end
				end
				flush_zero_width();
				// bits past the configured fields are dropped here
				if (hdr_seen >= hdr_len) begin
					new_packet();
					in_payload = !pend;
				end
			end
		end
		if (batch_n > 0) begin
			byte_batch[batch_n-1].last = 1'b1;
			byte_batch[batch_n-1].eop  = pend;
		end
		for (i = 0; i < batch_n; i++) begin
			result_store[res_wr % RESULT_SLOTS] = byte_batch[i];
			res_wr++;
		end
	endfunction

	function automatic logic [pfx_pkg::MAX_FIELDS-1:0][pfx_pkg::WIDTH_W-1:0] width_set(
		int a, int b, int c, int d, int e, int f);
		logic [pfx_pkg::MAX_FIELDS-1:0][pfx_pkg::WIDTH_W-1:0] w;
		w[0] = pfx_pkg::WIDTH_W'(a);
		w[1] = pfx_pkg::WIDTH_W'(b);
		w[2] = pfx_pkg::WIDTH_W'(c);
		w[3] = pfx_pkg::WIDTH_W'(d);
		w[4] = pfx_pkg::WIDTH_W'(e);
		w[5] = pfx_pkg::WIDTH_W'(f);
		return w;
	endfunction

	function automatic void add_byte(logic [pfx_pkg::BYTE_BITS-1:0] d, logic pend);
		byte_store[byte_wr % BYTE_SLOTS] = '{d, pend};
		byte_wr++;
	endfunction

	function automatic void add_packet(int n);
		int i;
		for (i = 0; i < n; i++)
			add_byte(pfx_pkg::BYTE_BITS'($urandom), i == n - 1);
	endfunction

	task automatic write_reg(pfx_pkg::reg_idx_t idx, logic [pfx_pkg::WIDTH_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic apply_setting(logic [pfx_pkg::FCOUNT_W-1:0] fc,
		logic [pfx_pkg::MAX_FIELDS-1:0][pfx_pkg::WIDTH_W-1:0] w,
		logic [pfx_pkg::HBYTES_W-1:0] hb);
		write_reg(pfx_pkg::REG_FIELD_COUNT, pfx_pkg::WIDTH_W'(fc));
		write_reg(pfx_pkg::REG_WIDTH_A, w[0]);
		write_reg(pfx_pkg::REG_WIDTH_B, w[1]);
		write_reg(pfx_pkg::REG_WIDTH_C, w[2]);
		write_reg(pfx_pkg::REG_WIDTH_D, w[3]);
		write_reg(pfx_pkg::REG_WIDTH_E, w[4]);
		write_reg(pfx_pkg::REG_WIDTH_F, w[5]);
		write_reg(pfx_pkg::REG_HEADER_BYTES, pfx_pkg::WIDTH_W'(hb));
		@(posedge clk);
		cfg_we     <= 1'b0;
		fld_count  = fc;
		fld_widths = w;
		hdr_len    = hb;
		settings_used++;
	endtask

	// Quiet final bytes give no result, so allow the pipeline to drain after the last one.
	task automatic settle();
		while (byte_wr != byte_rd || pkt_in.valid || res_wr != res_rd)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// byte driver
	always @(posedge clk) begin : drive_bytes
		pkt_byte_t nxt;
		if (!arst_n) begin
			pkt_in.valid <= 1'b0;
		end else begin
			if (pkt_in.valid && pkt_in.ready) begin
				extract_byte(pkt_in.data_byte, pkt_in.packet_end);
				bytes_fed++;
			end
			if (!pkt_in.valid || pkt_in.ready) begin
				if (byte_wr != byte_rd && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = byte_store[byte_rd % BYTE_SLOTS];
					byte_rd++;
					pkt_in.valid      <= 1'b1;
					pkt_in.data_byte  <= nxt.data;
					pkt_in.packet_end <= nxt.pend;
				end else begin
					pkt_in.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver; a requested hold-off keeps ready low while the LONG_HOLD countdown runs
	always @(posedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_out.ready <= 1'b0;
		end else begin
			res_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		field_result_t want;
		if (arst_n && res_out.valid && res_out.ready) begin
			if (res_wr == res_rd) begin
				$error("unexpected result beat: kind %0d index %0d value %h",
					res_out.kind, res_out.field_index, res_out.field_value);
				mismatches++;
			end else begin
				want = result_store[res_rd % RESULT_SLOTS];
				res_rd++;
				results_checked++;
				if (res_out.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res_out.kind);
					mismatches++;
				end
				if (res_out.field_index !== want.index) begin
					$error("field_index: expected %0d, got %0d", want.index,
						res_out.field_index);
					mismatches++;
				end
				if (res_out.field_value !== want.value) begin
					$error("field_value: expected %h, got %h", want.value,
						res_out.field_value);
					mismatches++;
				end
				if (res_out.end_of_packet !== want.eop) begin
					$error("end_of_packet: expected %0b, got %0b", want.eop,
						res_out.end_of_packet);
					mismatches++;
				end
				if (res_out.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res_out.last);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [pfx_pkg::MAX_FIELDS-1:0][pfx_pkg::WIDTH_W-1:0] w;
		logic [pfx_pkg::FCOUNT_W-1:0]                         fc;
		logic [pfx_pkg::HBYTES_W-1:0]                         hb;
		int mode, fed, len, i, total_w, quota;
		cfg_we            = 1'b0;
		cfg_index         = pfx_pkg::REG_FIELD_COUNT;
		cfg_data          = '0;
		pkt_in.valid      = 1'b0;
		pkt_in.data_byte  = '0;
		pkt_in.packet_end = 1'b0;
		res_out.ready     = 1'b0;
		fld_count         = '0;
		fld_widths        = '0;
		hdr_len           = '0;
		new_packet();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// middle field zero wide, header longer than the fields
		apply_setting(3'd3, width_set(3, 0, 13, 5, 5, 5), 6'd3);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hAA, 1'b0);
		add_byte(8'h55, 1'b1);
		// short packet
		add_byte(8'hFF, 1'b0);
		add_byte(8'h81, 1'b1);
		// header's last byte also ends the packet and completes nothing
		add_byte(8'h12, 1'b0);
		add_byte(8'h34, 1'b0);
		add_byte(8'h56, 1'b1);
		settle();

		// empty header: everything is payload, zero-width field never shows
		apply_setting(3'd1, width_set(0, 0, 0, 0, 0, 0), 6'd0);
		add_byte(8'h7F, 1'b1);
		add_byte(8'h80, 1'b0);
		add_byte(8'h01, 1'b1);
		settle();

		// zero-width field at the start; 64-bit field cut off by the header end
		apply_setting(3'd2, width_set(0, 64, 0, 0, 0, 0), 6'd2);
		add_byte(8'hC3, 1'b0);
		add_byte(8'h3C, 1'b0);
		add_byte(8'hEE, 1'b1);
		settle();

		// six one-bit fields from a single header byte
		apply_setting(3'd6, width_set(1, 1, 1, 1, 1, 1), 6'd1);
		add_byte(8'hA5, 1'b1);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h01, 1'b1);
		settle();

		// no fields at all: header taken silently
		apply_setting(3'd0, width_set(0, 0, 0, 0, 0, 0), 6'd1);
		add_byte(8'h11, 1'b0);
		add_byte(8'h22, 1'b1);
		settle();

		// everything at its top code: field count and widths clamp, longest header
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		apply_setting(3'd7, width_set(127, 127, 127, 127, 127, 127), 6'd63);
		add_packet(64);
		settle();

		for (mode = 0; mode < 4; mode++) begin
			fc      = pfx_pkg::FCOUNT_W'($urandom_range(0, 7));
			total_w = 0;
			for (i = 0; i < pfx_pkg::MAX_FIELDS; i++) begin
				case ($urandom_range(0, 9))
					0: w[i] = '0;
					1: w[i] = pfx_pkg::WIDTH_W'($urandom_range(64, 127));
					default: w[i] = pfx_pkg::WIDTH_W'($urandom_range(1, 20));
				endcase
				if (i < fc)
					total_w += (w[i] > 64) ? 64 : w[i];
			end
			if ($urandom_range(0, 3) == 0)
				hb = pfx_pkg::HBYTES_W'($urandom_range(0, 4));
			else
				hb = pfx_pkg::HBYTES_W'(((total_w + 7) / 8 > 8) ? 8 : (total_w + 7) / 8);
			case (mode)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct  = 33;
					recv_stall_pct = 33;
				end
			endcase
			apply_setting(fc, w, hb);
			quota = 5;
			// long back-pressure while bytes keep coming, so the input stalls
			if (mode == 0) begin
				hold_asked++;
				quota = 12;
			end
			fed = 0;
			while (fed < quota) begin
				if (hb > 0 && $urandom_range(0, 4) == 0)
					len = $urandom_range(1, hb);
				else
					len = hb + $urandom_range(0, 3);
				if (len == 0)
					len = 1;
				add_packet(len);
				fed += len;
			end
			settle();
		end

		$display("%0d packet bytes over %0d register settings, %0d result beats checked.",
			bytes_fed, settings_used, results_checked);
		$display("Covered short, quiet-ending, empty and clamped headers under idle and stall.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out with %0d results outstanding", res_wr - res_rd);
		$display("Test completed with failures");
		$finish;
	end

endmodule
